// ===== design/aalm_pkg.sv =====
// Package for the adaptive audio level meter.
// Holds widths, constants, control enums and controller/datapath structs.
// No dependencies.
package aalm_pkg;

  localparam int MAX_BLOCK   = 1024;
  localparam int CNT_W       = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W       = 26;
  localparam int LVL_W       = 14;
  localparam int DIV_W       = 26;
  localparam int DEN_W       = 16;
  localparam int DIV_CNT_W   = $clog2(DIV_W);
  localparam int METRIC_CAP  = 6000;

  // x / 100 equals (x * RECIP_100) >> RECIP_SHIFT for every x below 2**C100_W
  localparam int          C100_W      = 23;
  localparam int          RECIP_SHIFT = 30;
  localparam logic [23:0] RECIP_100   = 24'd10737419;

  localparam logic [1:0] REG_LEVEL_SCALE = 2'd0;
  localparam logic [1:0] REG_NOISE_GATE  = 2'd1;
  localparam logic [1:0] REG_MIN_SPAN    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAUNCH,
    S_WAIT,
    S_SEED,
    S_SPAN,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_ABS,
    OP_DIFF,
    OP_RAW,
    OP_MET,
    OP_FLOOR,
    OP_CEIL,
    OP_NORM,
    OP_SMOOTH
  } op_t;

  typedef struct packed {
    logic idle;
    logic launch;
    logic store;
    logic seed;
    logic span;
    logic emit;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic div_done;
    logic out_full;
  } status_t;

endpackage

// ===== design/aalm_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on aalm_pkg.
module aalm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [aalm_pkg::DIV_W-1:0] num,
  input  logic [aalm_pkg::DEN_W-1:0] den,
  output logic                       done,
  output logic [aalm_pkg::DIV_W-1:0] quo
);
  import aalm_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     dvs;
  logic [DIV_W-1:0]     q;
  logic [DEN_W:0]       trial;
  logic                 fits;

  assign trial = {rem, q[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvs});
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      rem <= fits ? DEN_W'(trial - {1'b0, dvs}) : trial[DEN_W-1:0];
      q   <= {q[DIV_W-2:0], fits};
    end else if (start) begin
      rem <= '0;
      dvs <= den;
      q   <= num;
    end
  end

endmodule

// ===== design/aalm_ctrl.sv =====
// Controller: sequences the block-end computation through its divide steps.
// Depends on aalm_pkg.
module aalm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  aalm_pkg::status_t status,
  output aalm_pkg::cmd_t    cmd
);
  import aalm_pkg::*;

  state_t state, state_next;
  op_t    op, op_next;

  always_comb begin
    state_next = state;
    op_next    = op;
    case (state)
      S_IDLE: begin
        if (in_valid && status.close) begin
          state_next = S_LAUNCH;
          op_next    = OP_ABS;
        end
      end
      S_LAUNCH: state_next = S_WAIT;
      S_WAIT: begin
        if (status.div_done) begin
          case (op)
            OP_MET:    state_next = S_SEED;
            OP_CEIL:   state_next = S_SPAN;
            OP_SMOOTH: state_next = S_EMIT;
            default: begin
              state_next = S_LAUNCH;
              op_next    = op_t'(op + 3'd1);
            end
          endcase
        end
      end
      S_SEED: begin
        state_next = S_LAUNCH;
        op_next    = OP_FLOOR;
      end
      S_SPAN: begin
        state_next = S_LAUNCH;
        op_next    = OP_NORM;
      end
      S_EMIT: if (!status.out_full) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.op     = op;
    cmd.idle   = (state == S_IDLE);
    cmd.launch = (state == S_LAUNCH);
    cmd.store  = (state == S_WAIT) && status.div_done;
    cmd.seed   = (state == S_SEED);
    cmd.span   = (state == S_SPAN);
    cmd.emit   = (state == S_EMIT) && !status.out_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_ABS;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

endmodule

// ===== design/aalm_dp.sv =====
// Datapath: config registers, accumulators, adaptive levels and output register.
// Depends on aalm_pkg and aalm_div.
module aalm_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  input  logic signed [15:0] sample,
  input  logic              block_end,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [7:0]        level,
  input  aalm_pkg::cmd_t    cmd,
  output aalm_pkg::status_t status
);
  import aalm_pkg::*;

  logic [15:0]      level_scale;
  logic [7:0]       noise_gate;
  logic [9:0]       min_gap;
  logic signed [15:0] previous_sample;
  logic             previous_valid;
  logic [SUM_W-1:0] abs_sum, diff_sum;
  logic [CNT_W-1:0] block_samples, diff_samples;
  logic [LVL_W-1:0] floor_level, ceiling_level;
  logic [7:0]       smoothed_level;
  logic [15:0]      avg_abs, mean_diff, raw_metric;
  logic [12:0]      metric;
  logic [7:0]       norm;

  logic             accept;
  logic [16:0]      mag_s, mag_d;
  logic signed [16:0] dlt;
  logic [CNT_W:0]   cnt_inc;
  logic [DIV_W-1:0] num, quo, div_quo;
  logic [DEN_W-1:0] den;
  logic             div_done;
  logic [LVL_W-1:0] span_w;
  logic [7:0]       norm_q;

  logic                by_const;
  logic [C100_W-1:0]   c_num;
  logic [C100_W+23:0]  c_prod;
  logic                c_stage, c_done;
  logic [15:0]         c_quo;

  assign accept  = in_valid && cmd.idle;
  assign mag_s   = sample[15] ? 17'(-{sample[15], sample}) : {1'b0, sample};
  assign dlt     = {sample[15], sample} - {previous_sample[15], previous_sample};
  assign mag_d   = dlt[16] ? 17'(-dlt) : 17'(dlt);
  assign cnt_inc = {1'b0, block_samples} + 1'b1;
  assign span_w  = ceiling_level - floor_level;

  // Steps that divide by 100 use the reciprocal path, the rest the serial divider
  assign by_const = (cmd.op == OP_RAW) || (cmd.op == OP_FLOOR) ||
                    (cmd.op == OP_CEIL) || (cmd.op == OP_SMOOTH);
  assign quo      = by_const ? DIV_W'(c_quo) : div_quo;

  assign status.close    = block_end || (cnt_inc >= (CNT_W+1)'(MAX_BLOCK));
  assign status.div_done = by_const ? c_done : div_done;
  assign status.out_full = out_valid;

  // Divider operand selection per step
  always_comb begin
    num = '0;
    den = 16'd100;
    case (cmd.op)
      OP_ABS: begin
        num = abs_sum;
        den = DEN_W'(block_samples);
      end
      OP_DIFF: begin
        num = diff_sum;
        den = DEN_W'(diff_samples);
      end
      OP_RAW: num = DIV_W'(avg_abs * 7'd55) + DIV_W'(mean_diff * 7'd45);
      OP_MET: begin
        num = DIV_W'(raw_metric * 10'd1000);
        den = (level_scale == '0) ? 16'd1 : level_scale;
      end
      OP_FLOOR: begin
        if ({1'b0, metric} <= floor_level)
          num = DIV_W'(floor_level * 7'd70) + DIV_W'(metric * 7'd30);
        else
          num = DIV_W'(floor_level * 7'd95) + DIV_W'(metric * 7'd5);
      end
      OP_CEIL: begin
        if ({1'b0, metric} >= ceiling_level)
          num = DIV_W'(ceiling_level * 7'd50) + DIV_W'(metric * 7'd50);
        else
          num = DIV_W'(ceiling_level * 7'd98) + DIV_W'(metric * 7'd2);
      end
      OP_NORM: begin
        num = DIV_W'(LVL_W'({1'b0, metric} - floor_level) * 8'd255);
        den = DEN_W'(span_w);
      end
      OP_SMOOTH: begin
        if (norm >= smoothed_level)
          num = DIV_W'(smoothed_level * 7'd35) + DIV_W'(norm * 7'd65) + DIV_W'(50);
        else
          num = DIV_W'(smoothed_level * 7'd58) + DIV_W'(norm * 7'd42) + DIV_W'(50);
      end
      default: num = '0;
    endcase
  end

  aalm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.launch && !by_const),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Divide by 100: capture the numerator, then multiply by the reciprocal
  assign c_prod = {24'd0, c_num} * {23'd0, RECIP_100};

  always_ff @(posedge clk) begin
    if (rst) begin
      c_stage <= 1'b0;
      c_done  <= 1'b0;
    end else begin
      c_stage <= cmd.launch && by_const;
      c_done  <= c_stage;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.launch) c_num <= num[C100_W-1:0];
    if (c_stage) c_quo <= c_prod[RECIP_SHIFT+15:RECIP_SHIFT];
  end

  always_comb begin
    if (({1'b0, metric} > floor_level) && (span_w != '0))
      norm_q = (quo > DIV_W'(255)) ? 8'd255 : quo[7:0];
    else
      norm_q = '0;
    if (norm_q <= noise_gate) norm_q = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_scale     <= 16'd7000;
      noise_gate      <= 8'd5;
      min_gap         <= 10'd110;
      previous_sample <= '0;
      previous_valid  <= 1'b0;
      abs_sum         <= '0;
      diff_sum        <= '0;
      block_samples   <= '0;
      diff_samples    <= '0;
      floor_level     <= '0;
      ceiling_level   <= '0;
      smoothed_level  <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_LEVEL_SCALE: level_scale <= cfg_data;
          REG_NOISE_GATE:  noise_gate  <= cfg_data[7:0];
          REG_MIN_SPAN:    min_gap     <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;

      if (accept) begin
        abs_sum         <= abs_sum + SUM_W'(mag_s);
        block_samples   <= cnt_inc[CNT_W-1:0];
        previous_sample <= sample;
        previous_valid  <= 1'b1;
        if (previous_valid) begin
          diff_sum     <= diff_sum + SUM_W'(mag_d);
          diff_samples <= diff_samples + 1'b1;
        end
      end

      if (cmd.store) begin
        case (cmd.op)
          OP_FLOOR:  floor_level    <= quo[LVL_W-1:0];
          OP_CEIL:   ceiling_level  <= quo[LVL_W-1:0];
          OP_SMOOTH: smoothed_level <= quo[7:0];
          default: ;
        endcase
      end

      if (cmd.seed && ceiling_level == '0) begin
        floor_level   <= LVL_W'(metric);
        ceiling_level <= LVL_W'(metric) + LVL_W'(min_gap);
      end

      if (cmd.span && ((ceiling_level < floor_level) ||
                       (span_w < LVL_W'(min_gap))))
        ceiling_level <= floor_level + LVL_W'(min_gap);

      if (cmd.emit) begin
        out_valid     <= 1'b1;
        abs_sum       <= '0;
        diff_sum      <= '0;
        block_samples <= '0;
        diff_samples  <= '0;
      end
    end
  end

  // Result registers of the division steps
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      case (cmd.op)
        OP_ABS:  avg_abs <= quo[15:0];
        OP_DIFF: mean_diff <= (diff_samples == '0) ? 16'd0 : quo[15:0];
        OP_RAW:  raw_metric <= quo[15:0];
        OP_MET:  metric <= (quo > DIV_W'(METRIC_CAP)) ? 13'(METRIC_CAP) : quo[12:0];
        OP_NORM: norm <= norm_q;
        default: ;
      endcase
    end
    if (cmd.emit) level <= smoothed_level;
  end

endmodule

// ===== design/adaptive_audio_level_meter.sv =====
// Adaptive audio level meter, top: joins aalm_ctrl and aalm_dp, uses aalm_pkg.
// A sample that does not close a block is taken without stalling the input. A closing
// item runs four passes of the serial divider and four divides by 100, plus seed,
// span and output steps, before level is valid. The input stalls meanwhile, and
// longer while the previous level is unread. Reset (rst, synchronous) restores
// register defaults and clears the controller, accumulators and adaptive levels.
module adaptive_audio_level_meter (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] sample,
  input  logic               block_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         level
);
  import aalm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Hold off new samples while a block end is being worked through
  assign in_stall = !cmd.idle;

  aalm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd)
  );

  aalm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .sample    (sample),
    .block_end (block_end),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .level     (level),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
